// ===== rtl/tctw_pkg.sv =====
package tctw_pkg;

	localparam int MAX_COLUMNS = 128;
	localparam int MAX_ROWS    = 64;
	localparam int TAB_SPACES  = 4;

	localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
	localparam int AW     = $clog2(DEPTH);
	localparam int PW     = AW + 1;
	localparam int LIM_W  = $clog2(DEPTH + 1);
	localparam int CELL_W = 16;
	localparam int COL_W  = $clog2(MAX_COLUMNS);
	localparam int ROW_W  = $clog2(MAX_ROWS + TAB_SPACES);
	localparam int DCNT_W = $clog2(AW);
	localparam int TC_W   = $clog2(TAB_SPACES + 1);

	localparam int CMD_W      = 3;
	localparam int CHAR_W     = 8;
	localparam int ATTR_W     = 8;
	localparam int TROW_W     = 6;
	localparam int TCOL_W     = 7;
	localparam int RPT_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam int CW         = 8;
	localparam int RW         = 7;

	localparam logic [CW-1:0] COLS_RST = CW'(80);
	localparam logic [RW-1:0] ROWS_RST = RW'(25);

	localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b1;

	localparam logic [CMD_W-1:0] CMD_TTY    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SETCUR = 3'd1;
	localparam logic [CMD_W-1:0] CMD_WRCA   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_WRC    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_NORM_A, ST_NORM_B, ST_NORM_C, ST_DIV, ST_EXEC,
		ST_STEP, ST_KEEP, ST_RDCAP, ST_CHECK, ST_SCR_RD, ST_SCR_WR, ST_FILL,
		ST_FINISH
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_CLEAR, OP_NORM_A, OP_NORM_B, OP_NORM_C, OP_DIV,
		OP_EXEC, OP_STEP, OP_KEEP, OP_RDCAP, OP_SCR_INIT, OP_SCR_RD, OP_SCR_WR,
		OP_FILL, OP_OUT
	} op_t;

	typedef enum logic [1:0] {K_SINGLE, K_STEP, K_KEEP, K_READ} kind_t;

	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic  clr_last;
		logic  dirty;
		logic  div_last;
		kind_t kind;
		logic  step_last;
		logic  scroll_need;
		logic  copy_done;
		logic  fill_last;
		logic  out_free;
	} dp_sts_t;

endpackage

// ===== rtl/text_console_teletype_writer_top.sv =====
// Text console engine: a 8192-cell char/attribute store with a cursor, serving teletype,
// set cursor, write char (+attr) and read cell; one result item per input item, one item
// in work at a time. After reset a clearing pass over all 8192 cells runs before the first
// item. Most commands go through accept, execute, scroll check and result; a printable
// teletype char adds a store write, a tab one store write per cell, write-char-only and
// read a wait for the store read. A scroll reads and then writes each moved cell, as the
// store has one write port, and then fills the last row. The first item after a geometry
// write first runs the normalisation steps and the bit-serial divider that splits the
// linear cursor into row and column.
module text_console_teletype_writer_top import tctw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [CHAR_W-1:0]     char_code,
	input  logic [ATTR_W-1:0]     attribute,
	input  logic [TROW_W-1:0]     target_row,
	input  logic [TCOL_W-1:0]     target_column,
	input  logic [RPT_W-1:0]      repeat_count,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CHAR_W-1:0]     read_char,
	output logic [ATTR_W-1:0]     read_attribute,
	output logic [TROW_W-1:0]     cursor_row,
	output logic [TCOL_W-1:0]     cursor_column
);

	dp_cmd_t dcmd;
	dp_sts_t sts;

	tctw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd_o    (dcmd)
	);

	tctw_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.char_code      (char_code),
		.attribute      (attribute),
		.target_row     (target_row),
		.target_column  (target_column),
		.repeat_count   (repeat_count),
		.dcmd           (dcmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_char      (read_char),
		.read_attribute (read_attribute),
		.cursor_row     (cursor_row),
		.cursor_column  (cursor_column)
	);

endmodule

// ===== rtl/tctw_ram.sv =====
module tctw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/tctw_ctrl.sv =====
module tctw_ctrl import tctw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd_o
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (sts.clr_last) state_d = ST_IDLE;
			ST_IDLE:   if (in_valid) state_d = sts.dirty ? ST_NORM_A : ST_EXEC;
			ST_NORM_A: state_d = ST_NORM_B;
			ST_NORM_B: state_d = ST_NORM_C;
			ST_NORM_C: state_d = ST_DIV;
			ST_DIV:    if (sts.div_last) state_d = ST_EXEC;
			ST_EXEC: begin
				case (sts.kind)
					K_STEP:  state_d = ST_STEP;
					K_KEEP:  state_d = ST_KEEP;
					K_READ:  state_d = ST_RDCAP;
					default: state_d = ST_CHECK;
				endcase
			end
			ST_STEP:   if (sts.step_last) state_d = ST_CHECK;
			ST_KEEP:   state_d = ST_CHECK;
			ST_RDCAP:  state_d = ST_CHECK;
			ST_CHECK:  state_d = sts.scroll_need ? ST_SCR_RD : ST_FINISH;
			ST_SCR_RD: state_d = sts.copy_done ? ST_FILL : ST_SCR_WR;
			ST_SCR_WR: state_d = ST_SCR_RD;
			ST_FILL:   if (sts.fill_last) state_d = ST_FINISH;
			ST_FINISH: if (sts.out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_o.op = OP_NONE;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_CLEAR:  cmd_o.op = OP_CLEAR;
			ST_IDLE:   if (in_valid) cmd_o.op = OP_LOAD;
			ST_NORM_A: cmd_o.op = OP_NORM_A;
			ST_NORM_B: cmd_o.op = OP_NORM_B;
			ST_NORM_C: cmd_o.op = OP_NORM_C;
			ST_DIV:    cmd_o.op = OP_DIV;
			ST_EXEC:   cmd_o.op = OP_EXEC;
			ST_STEP:   cmd_o.op = OP_STEP;
			ST_KEEP:   cmd_o.op = OP_KEEP;
			ST_RDCAP:  cmd_o.op = OP_RDCAP;
			ST_CHECK:  if (sts.scroll_need) cmd_o.op = OP_SCR_INIT;
			ST_SCR_RD: if (!sts.copy_done) cmd_o.op = OP_SCR_RD;
			ST_SCR_WR: cmd_o.op = OP_SCR_WR;
			ST_FILL:   cmd_o.op = OP_FILL;
			ST_FINISH: if (sts.out_free) cmd_o.op = OP_OUT;
			default:   cmd_o.op = OP_NONE;
		endcase
	end

endmodule

// ===== rtl/tctw_dp.sv =====
module tctw_dp import tctw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [CHAR_W-1:0]     char_code,
	input  logic [ATTR_W-1:0]     attribute,
	input  logic [TROW_W-1:0]     target_row,
	input  logic [TCOL_W-1:0]     target_column,
	input  logic [RPT_W-1:0]      repeat_count,
	input  dp_cmd_t               dcmd,
	output dp_sts_t               sts,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CHAR_W-1:0]     read_char,
	output logic [ATTR_W-1:0]     read_attribute,
	output logic [TROW_W-1:0]     cursor_row,
	output logic [TCOL_W-1:0]     cursor_column
);

	logic [CW-1:0]     cols_cfg_q, colse_q, cols_eff;
	logic [RW-1:0]     rows_cfg_q, rowse_q, rows_eff;
	logic              dirty_q;
	logic [LIM_W-1:0]  limit_q, last;
	logic [PW-1:0]     pos_q, idx_q, pos_c;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [AW-1:0]     quo_q, quo_n;
	logic [CW-1:0]     rem_q, rem_n;
	logic [CW:0]       div_t;
	logic              div_ge;
	logic [DCNT_W-1:0] dcnt_q;
	logic [TC_W-1:0]   step_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [CHAR_W-1:0] ch_q, rdc_q;
	logic [ATTR_W-1:0] attr_q, rda_q;
	logic [TROW_W-1:0] trow_q;
	logic [TCOL_W-1:0] tcol_q;
	logic              cnt_nz_q, is_tab;
	logic [RW-1:0]     trow_c;
	logic [CW-1:0]     tcol_c;
	logic              out_valid_q;
	logic [CHAR_W-1:0] out_ch_q;
	logic [ATTR_W-1:0] out_at_q;
	logic [TROW_W-1:0] out_row_q;
	logic [TCOL_W-1:0] out_col_q;
	logic [CW-1:0]     wr_cols_raw, wr_cols;
	logic [RW-1:0]     wr_rows_raw, wr_rows;
	logic [LIM_W-1:0]  wr_limit;

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [CELL_W-1:0] ram_wdata, ram_rdata;

	tctw_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		if (cols_cfg_q == '0) cols_eff = CW'(1);
		else if (cols_cfg_q > CW'(MAX_COLUMNS)) cols_eff = CW'(MAX_COLUMNS);
		else cols_eff = cols_cfg_q;
		if (rows_cfg_q == '0) rows_eff = RW'(1);
		else if (rows_cfg_q > RW'(MAX_ROWS)) rows_eff = RW'(MAX_ROWS);
		else rows_eff = rows_cfg_q;
	end

	// geometry as it stands after the register write of this cycle
	always_comb begin
		wr_cols_raw = (cfg_index == REG_COLS) ? cfg_data : cols_cfg_q;
		wr_rows_raw = (cfg_index == REG_ROWS) ? cfg_data[RW-1:0] : rows_cfg_q;
		if (wr_cols_raw == '0) wr_cols = CW'(1);
		else if (wr_cols_raw > CW'(MAX_COLUMNS)) wr_cols = CW'(MAX_COLUMNS);
		else wr_cols = wr_cols_raw;
		if (wr_rows_raw == '0) wr_rows = RW'(1);
		else if (wr_rows_raw > RW'(MAX_ROWS)) wr_rows = RW'(MAX_ROWS);
		else wr_rows = wr_rows_raw;
		wr_limit = LIM_W'(wr_cols) * LIM_W'(wr_rows);
	end

	assign last   = limit_q - LIM_W'(colse_q);
	assign pos_c  = (pos_q >= limit_q) ? last : pos_q;
	assign div_t  = {rem_q, quo_q[AW-1]};
	assign div_ge = (div_t >= {1'b0, colse_q});
	assign rem_n  = div_ge ? CW'(div_t - {1'b0, colse_q}) : div_t[CW-1:0];
	assign quo_n  = {quo_q[AW-2:0], div_ge};
	assign is_tab = (ch_q == CH_TAB);
	assign trow_c = ({1'b0, trow_q} > rowse_q - RW'(1)) ? rowse_q - RW'(1) : {1'b0, trow_q};
	assign tcol_c = ({1'b0, tcol_q} > colse_q - CW'(1)) ? colse_q - CW'(1) : {1'b0, tcol_q};

	always_comb begin
		sts.clr_last    = (idx_q == PW'(DEPTH - 1));
		sts.dirty       = dirty_q;
		sts.div_last    = (dcnt_q == DCNT_W'(AW - 1));
		sts.step_last   = !is_tab || (step_q == TC_W'(TAB_SPACES - 1));
		sts.scroll_need = (row_q >= ROW_W'(rowse_q));
		sts.copy_done   = (idx_q == last);
		sts.fill_last   = (idx_q == limit_q - LIM_W'(1));
		sts.out_free    = !out_valid_q || !out_stall;
		sts.kind        = K_SINGLE;
		case (cmd_q)
			CMD_TTY: begin
				if (ch_q != CH_LF && ch_q != CH_CR && ch_q != CH_BS) sts.kind = K_STEP;
			end
			CMD_WRC:  sts.kind = K_KEEP;
			CMD_READ: sts.kind = K_READ;
			default:  sts.kind = K_SINGLE;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q[AW-1:0];
		ram_wdata = {attr_q, ch_q};
		ram_re    = 1'b0;
		ram_raddr = pos_q[AW-1:0];
		case (dcmd.op)
			OP_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q[AW-1:0];
				ram_wdata = '0;
			end
			OP_EXEC: begin
				ram_we = (cmd_q == CMD_WRCA) && cnt_nz_q;
				ram_re = (cmd_q == CMD_WRC) || (cmd_q == CMD_READ);
			end
			OP_STEP: begin
				ram_we    = (row_q < ROW_W'(rowse_q));
				ram_wdata = {attr_q, is_tab ? CH_SPACE : ch_q};
			end
			OP_KEEP: begin
				ram_we    = cnt_nz_q;
				ram_wdata = {ram_rdata[CELL_W-1:CHAR_W], ch_q};
			end
			OP_SCR_RD: begin
				ram_re    = 1'b1;
				ram_raddr = AW'(idx_q + PW'(colse_q));
			end
			OP_SCR_WR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q[AW-1:0];
				ram_wdata = ram_rdata;
			end
			OP_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q[AW-1:0];
				ram_wdata = {attr_q, CH_SPACE};
			end
			default: ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_cfg_q  <= COLS_RST;
			rows_cfg_q  <= ROWS_RST;
			colse_q     <= COLS_RST;
			rowse_q     <= ROWS_RST;
			limit_q     <= LIM_W'(COLS_RST * ROWS_RST);
			dirty_q     <= 1'b0;
			pos_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (dcmd.op)
				OP_CLEAR:  idx_q <= idx_q + PW'(1);
				OP_NORM_A: begin
					colse_q <= cols_eff;
					rowse_q <= rows_eff;
				end
				OP_NORM_B: limit_q <= LIM_W'(colse_q * rowse_q);
				OP_NORM_C: pos_q <= pos_c;
				OP_DIV: begin
					if (sts.div_last) begin
						row_q   <= ROW_W'(quo_n);
						col_q   <= rem_n[COL_W-1:0];
						dirty_q <= 1'b0;
					end
				end
				OP_EXEC: begin
					case (cmd_q)
						CMD_TTY: begin
							case (ch_q)
								CH_LF: begin
									pos_q <= pos_q + PW'(colse_q);
									row_q <= row_q + ROW_W'(1);
								end
								CH_CR: begin
									pos_q <= pos_q - PW'(col_q);
									col_q <= '0;
								end
								CH_BS: begin
									if (col_q != '0) begin
										pos_q <= pos_q - PW'(1);
										col_q <= col_q - COL_W'(1);
									end
								end
								default: pos_q <= pos_q;
							endcase
						end
						CMD_SETCUR: begin
							pos_q <= PW'(trow_c * colse_q) + PW'(tcol_c);
							row_q <= ROW_W'(trow_c);
							col_q <= tcol_c[COL_W-1:0];
						end
						default: pos_q <= pos_q;
					endcase
				end
				OP_STEP: begin
					pos_q <= pos_q + PW'(1);
					if ({1'b0, col_q} == colse_q - CW'(1)) begin
						col_q <= '0;
						row_q <= row_q + ROW_W'(1);
					end else begin
						col_q <= col_q + COL_W'(1);
					end
				end
				OP_SCR_INIT: idx_q <= '0;
				OP_SCR_WR:   idx_q <= idx_q + PW'(1);
				OP_FILL: begin
					idx_q <= idx_q + PW'(1);
					if (sts.fill_last) begin
						pos_q <= last;
						row_q <= ROW_W'(rowse_q - RW'(1));
						col_q <= '0;
					end
				end
				OP_OUT: out_valid_q <= 1'b1;
				default: idx_q <= idx_q;
			endcase
			if (cfg_we) begin
				case (cfg_index)
					REG_COLS: cols_cfg_q <= cfg_data;
					REG_ROWS: rows_cfg_q <= cfg_data[RW-1:0];
					default:  cols_cfg_q <= cols_cfg_q;
				endcase
				// cursor off the new screen goes to the start of its last row
				if (pos_q >= PW'(wr_limit)) begin
					pos_q <= PW'(wr_limit - LIM_W'(wr_cols));
				end
				dirty_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (dcmd.op)
			OP_LOAD: begin
				cmd_q    <= cmd;
				ch_q     <= char_code;
				attr_q   <= attribute;
				trow_q   <= target_row;
				tcol_q   <= target_column;
				cnt_nz_q <= (repeat_count != '0);
			end
			OP_NORM_C: begin
				quo_q  <= pos_c[AW-1:0];
				rem_q  <= '0;
				dcnt_q <= '0;
			end
			OP_DIV: begin
				quo_q  <= quo_n;
				rem_q  <= rem_n;
				dcnt_q <= dcnt_q + DCNT_W'(1);
			end
			OP_EXEC: step_q <= '0;
			OP_STEP: step_q <= step_q + TC_W'(1);
			OP_RDCAP: begin
				rdc_q <= ram_rdata[CHAR_W-1:0];
				rda_q <= ram_rdata[CELL_W-1:CHAR_W];
			end
			OP_OUT: begin
				out_ch_q  <= (cmd_q == CMD_READ) ? rdc_q : '0;
				out_at_q  <= (cmd_q == CMD_READ) ? rda_q : '0;
				out_row_q <= row_q[TROW_W-1:0];
				out_col_q <= col_q;
			end
			default: cmd_q <= cmd_q;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign read_char      = out_ch_q;
	assign read_attribute = out_at_q;
	assign cursor_row     = out_row_q;
	assign cursor_column  = out_col_q;

endmodule

// ===== rtl/tctw_checker.sv =====
module tctw_checker import tctw_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic [CMD_W-1:0]      cmd,
	input logic [CHAR_W-1:0]     char_code,
	input logic [ATTR_W-1:0]     attribute,
	input logic [TROW_W-1:0]     target_row,
	input logic [TCOL_W-1:0]     target_column,
	input logic [RPT_W-1:0]      repeat_count,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [CHAR_W-1:0]     read_char,
	input logic [ATTR_W-1:0]     read_attribute,
	input logic [TROW_W-1:0]     cursor_row,
	input logic [TCOL_W-1:0]     cursor_column
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(cursor_row) && $stable(cursor_column)
		&& $stable(read_char) && $stable(read_attribute))
		else $error("stalled result item changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while one is in work");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result item appeared with no item in work");

endmodule

bind text_console_teletype_writer_top tctw_checker u_tctw_checker (.*);
